// ===== hw/rtl/bcd_pkg.sv =====
// shared types and constants of the button chord detector
package bcd_pkg;

  localparam int unsigned PressedW = 4;
  localparam int unsigned NowW     = 32;
  localparam int unsigned QueryW   = 3;
  localparam int unsigned ButtonW  = 3;
  localparam int unsigned SettleW  = 16;

  localparam logic [SettleW-1:0] SettleMsReset = 16'd50;

  // event codes of a result transaction
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SINGLE    = 2'd1,
    EV_BANK_DOWN = 2'd2,
    EV_BANK_UP   = 2'd3
  } event_e;

  // one button sample as it sits in the input register
  typedef struct packed {
    logic [PressedW-1:0] pressed;
    logic [NowW-1:0]     now_ms;
    logic                force_wait;
    logic [QueryW-1:0]   release_query;
  } sample_t;

  // one classification result
  typedef struct packed {
    event_e             event_res;
    logic [ButtonW-1:0] button;
    logic               released;
  } result_t;

endpackage

// ===== hw/rtl/bcd_if.sv =====
// valid/ready channel interfaces for samples, results and configuration

interface bcd_in_if;
  logic                           valid;
  logic                           ready;
  logic [bcd_pkg::PressedW-1:0]   pressed;
  logic [bcd_pkg::NowW-1:0]       now_ms;
  logic                           force_wait;
  logic [bcd_pkg::QueryW-1:0]     release_query;

  modport source (output valid, pressed, now_ms, force_wait, release_query, input ready);
  modport sink   (input valid, pressed, now_ms, force_wait, release_query, output ready);
endinterface

interface bcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     event_res;
  logic [bcd_pkg::ButtonW-1:0]    button;
  logic                           released;

  modport source (output valid, event_res, button, released, input ready);
  modport sink   (input valid, event_res, button, released, output ready);
endinterface

interface bcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bcd_pkg::SettleW-1:0]    settle_ms;

  modport source (output valid, settle_ms, input ready);
  modport sink   (input valid, settle_ms, output ready);
endinterface

// ===== hw/rtl/bcd_fsm.sv =====
// press/release state machine with chord classification and release query
module bcd_fsm #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  bcd_pkg::sample_t              sample_i,
  input  logic [bcd_pkg::SettleW-1:0]   settle_ms_i,
  output bcd_pkg::result_t              result_o
);
  import bcd_pkg::*;

  // buttons above BUTTONS are not wired
  localparam logic [PressedW-1:0] HeldMask =
    (BUTTONS >= PressedW) ? {PressedW{1'b1}} : PressedW'((1 << BUTTONS) - 1);

  localparam logic [PressedW-1:0] ChordDown = 4'b0011;
  localparam logic [PressedW-1:0] ChordUp   = 4'b0110;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SETTLE  = 4'b0010,
    PH_INVALID = 4'b0100,
    PH_WAIT    = 4'b1000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [NowW-1:0]     mark_q, mark_d;
  logic [ButtonW-1:0]  last_q, last_d;

  logic [PressedW-1:0] held;
  logic [NowW-1:0]     delta;
  logic                elapsed;
  logic [2:0]          held_cnt;
  logic [ButtonW-1:0]  lowest;
  logic [ButtonW-1:0]  last_cand;
  logic [QueryW-1:0]   query_m1;
  logic                query_held;
  event_e              ev;
  logic [ButtonW-1:0]  btn;
  logic                rel;

  // sample decode
  assign held     = sample_i.pressed & HeldMask;
  assign delta    = sample_i.now_ms - mark_q;
  assign elapsed  = delta > {{(NowW-SettleW){1'b0}}, settle_ms_i};
  assign held_cnt = 3'($countones(held));

  // lowest held button, numbered from one
  always_comb begin
    lowest = '0;
    for (int i = PressedW - 1; i >= 0; i--) begin
      if (held[i]) begin
        lowest = ButtonW'(i + 1);
      end
    end
  end

  // phase advance, classification and report
  always_comb begin
    phase_d   = phase_q;
    mark_d    = mark_q;
    last_cand = last_q;
    ev        = EV_NONE;
    btn       = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (held != '0) begin
          phase_d = PH_SETTLE;
          mark_d  = sample_i.now_ms;
        end
      end
      PH_SETTLE: begin
        if (elapsed) begin
          mark_d = sample_i.now_ms;
          priority if (held_cnt == 3'd1) begin
            ev        = EV_SINGLE;
            btn       = lowest;
            last_cand = lowest;
            phase_d   = PH_WAIT;
          end else if (held == ChordDown) begin
            ev      = sample_i.force_wait ? EV_NONE : EV_BANK_DOWN;
            phase_d = PH_WAIT;
          end else if (held == ChordUp) begin
            ev      = sample_i.force_wait ? EV_NONE : EV_BANK_UP;
            phase_d = PH_WAIT;
          end else begin
            phase_d = sample_i.force_wait ? PH_WAIT : PH_INVALID;
          end
        end
      end
      PH_INVALID: begin
        priority if (elapsed && held == '0) begin
          phase_d = PH_IDLE;
        end else if (sample_i.force_wait) begin
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (elapsed && held == '0) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // release query against the last single press
  assign query_m1   = sample_i.release_query - QueryW'(1);
  assign query_held = (query_m1 < QueryW'(PressedW)) && held[query_m1[1:0]];

  always_comb begin
    rel    = 1'b0;
    last_d = last_cand;
    if (sample_i.release_query != '0 && sample_i.release_query == last_cand && !query_held) begin
      rel    = 1'b1;
      last_d = '0;
    end
  end

  assign result_o.event_res = ev;
  assign result_o.button    = btn;
  assign result_o.released  = rel;

  // state registers, updated once per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mark_q  <= '0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      last_q  <= last_d;
    end
  end

  // checks
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase register not one-hot");

  a_single_has_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.event_res == EV_SINGLE |-> result_o.button != '0)
    else $error("single press without button number");

  a_event_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.event_res != EV_NONE |=> phase_q == PH_WAIT)
    else $error("reported event did not lead to wait for release");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.released |=> last_q == '0)
    else $error("last single not cleared after release");

endmodule

// ===== hw/rtl/button_chord_detector.sv =====
// Button chord detector: takes one button sample transaction per clock while
// results are taken and returns one result transaction per sample, through
// the input register, then the result register. The sustained rate is one
// sample per cycle; it is set by the state loop through the classifier, which
// is combinational. Backpressure on the result channel stalls the input
// register and then the sample channel. The settle window register (reset
// 50 ms) is written over its own channel, which is always ready.
module button_chord_detector #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcd_in_if.sink    item_i,
  bcd_cfg_if.sink   cfg_i,
  bcd_out_if.source result_o
);
  import bcd_pkg::*;

  logic                s1_valid_q;
  sample_t             s1_q;
  logic                s1_fire;
  logic                out_valid_q;
  result_t             out_q;
  result_t             fsm_res;
  logic [SettleW-1:0]  settle_q;

  // pipeline handshake
  assign s1_fire      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || s1_fire;
  assign cfg_i.ready  = 1'b1;

  // settle window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleMsReset;
    end else if (cfg_i.valid) begin
      settle_q <= cfg_i.settle_ms;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_q.pressed       <= item_i.pressed;
      s1_q.now_ms        <= item_i.now_ms;
      s1_q.force_wait    <= item_i.force_wait;
      s1_q.release_query <= item_i.release_query;
    end
  end

  // classifier and state
  bcd_fsm #(
    .BUTTONS (BUTTONS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .sample_i    (s1_q),
    .settle_ms_i (settle_q),
    .result_o    (fsm_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= fsm_res;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.event_res = out_q.event_res;
  assign result_o.button    = out_q.button;
  assign result_o.released  = out_q.released;

endmodule

// ===== bench/button_chord_detector_checker.sv =====
// checker that predicts and compares the result transactions of the chord detector
`timescale 1ns / 1ps

module button_chord_detector_checker #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  bcd_in_if    sample_mon,
  bcd_cfg_if   cfg_mon,
  bcd_out_if   result_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   events_o
);
  import bcd_pkg::*;

  localparam logic [PressedW-1:0] HeldMask = PressedW'((1 << BUTTONS) - 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_SETTLE  = 3'd1,
    ST_SINGLE  = 3'd2,
    ST_DOWN    = 3'd3,
    ST_UP      = 3'd4,
    ST_INVALID = 3'd5,
    ST_WAIT    = 3'd6
  } chord_phase_e;

  chord_phase_e       phase;
  logic [NowW-1:0]    mark_ms;
  logic [ButtonW-1:0] last_single;
  logic [SettleW-1:0] window_ms;
  result_t            expected_q[$];

  // advance the chord state by one sample and return the result it causes
  function automatic result_t classify_sample(sample_t s);
    logic [PressedW-1:0] held;
    logic                elapsed;
    logic                is_held;
    result_t             r;
    held        = s.pressed & HeldMask;
    elapsed     = (s.now_ms - mark_ms) > {{(NowW-SettleW){1'b0}}, window_ms};
    r.event_res = EV_NONE;
    r.button    = '0;
    r.released  = 1'b0;

    // phase advance with this sample
    case (phase)
      ST_IDLE: begin
        if (held != '0) begin
          phase   = ST_SETTLE;
          mark_ms = s.now_ms;
        end
      end
      ST_SETTLE: begin
        if (elapsed) begin
          if ($countones(held) == 1) phase = ST_SINGLE;
          else if (held == 4'b0011) phase = ST_DOWN;
          else if (held == 4'b0110) phase = ST_UP;
          else phase = ST_INVALID;
          mark_ms = s.now_ms;
        end
      end
      default: begin
        if ((phase == ST_INVALID || phase == ST_WAIT) && elapsed && held == '0) begin
          phase = ST_IDLE;
        end
      end
    endcase

    // report, or discard a chord or an invalid combination on force wait
    if (phase == ST_SINGLE) begin
      last_single = '0;
      for (int i = PressedW - 1; i >= 0; i--) begin
        if (held[i]) last_single = ButtonW'(i + 1);
      end
      r.event_res = EV_SINGLE;
      r.button    = last_single;
      phase       = ST_WAIT;
    end else if (s.force_wait &&
                 (phase == ST_DOWN || phase == ST_UP || phase == ST_INVALID)) begin
      phase = ST_WAIT;
    end else if (phase == ST_DOWN) begin
      r.event_res = EV_BANK_DOWN;
      phase       = ST_WAIT;
    end else if (phase == ST_UP) begin
      r.event_res = EV_BANK_UP;
      phase       = ST_WAIT;
    end

    // release query against the last single button
    if (s.release_query != '0 && s.release_query == last_single) begin
      is_held = (s.release_query <= BUTTONS) && held[s.release_query - 1'b1];
      if (!is_held) begin
        r.released  = 1'b1;
        last_single = '0;
      end
    end
    return r;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    result_t want;
    if (!rst_ni) begin
      phase       = ST_IDLE;
      mark_ms     = '0;
      last_single = '0;
      window_ms   = SettleMsReset;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      events_o     = 0;
    end else begin
      // result transaction against the oldest expectation
      if (result_mon.valid && result_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result ev=%0d btn=%0d rel=%0d", $time,
                   result_mon.event_res, result_mon.button, result_mon.released);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (result_mon.event_res !== want.event_res ||
              result_mon.button !== want.button ||
              result_mon.released !== want.released) begin
            $display("%0t: result mismatch: expected ev=%0d btn=%0d rel=%0d, got ev=%0d btn=%0d rel=%0d",
                     $time, want.event_res, want.button, want.released,
                     result_mon.event_res, result_mon.button, result_mon.released);
            fail_count_o++;
          end
        end
      end
      // settle window write
      if (cfg_mon.valid && cfg_mon.ready) begin
        window_ms = cfg_mon.settle_ms;
      end
      // sample transaction into the expectation store
      if (sample_mon.valid && sample_mon.ready) begin
        s.pressed       = sample_mon.pressed;
        s.now_ms        = sample_mon.now_ms;
        s.force_wait    = sample_mon.force_wait;
        s.release_query = sample_mon.release_query;
        want = classify_sample(s);
        if (want.event_res != EV_NONE) events_o++;
        expected_q.push_back(want);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/button_chord_detector_test.sv =====
// top of the chord detector testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module button_chord_detector_test;
  import bcd_pkg::*;

  localparam int unsigned Buttons      = 4;
  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned NumSettings  = 8;
  localparam int unsigned SamplesPerWindow = 172;

  logic clk_i;
  logic rst_ni;

  bcd_in_if  sample_ch ();
  bcd_cfg_if cfg_ch ();
  bcd_out_if result_ch ();

  int fail_count;
  int pending;
  int checked;
  int events;

  logic [NowW-1:0]    cur_now;
  logic [SettleW-1:0] window;
  int unsigned        samples_sent;
  bit                 burst_mode;

  button_chord_detector #(
    .BUTTONS (Buttons)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (sample_ch),
    .cfg_i    (cfg_ch),
    .result_o (result_ch)
  );

  button_chord_detector_checker #(
    .BUTTONS (Buttons)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_ch),
    .cfg_mon      (cfg_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .events_o     (events)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side: random stall before each result transaction
  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      @(negedge clk_i);
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
    $display("button_chord_detector_test: FAIL");
    $finish;
  end

  // one sample transaction after a random gap, returns at a falling edge
  task automatic send_sample(input logic [PressedW-1:0] p, input logic [NowW-1:0] t,
                             input logic f, input logic [QueryW-1:0] q);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.pressed       <= p;
    sample_ch.now_ms        <= t;
    sample_ch.force_wait    <= f;
    sample_ch.release_query <= q;
    cur_now = t;
    do @(posedge clk_i); while (!sample_ch.ready);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // hold off the sender until every result has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // settle window write while the block is idle
  task automatic write_settle(input logic [SettleW-1:0] v);
    drain_results();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.settle_ms <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    window = v;
  endtask

  // time step around the settle window, with the odd wrap-around jump
  function automatic logic [NowW-1:0] pick_step();
    int unsigned r;
    int unsigned w;
    r = $urandom_range(0, 99);
    w = window;
    if (r < 35) return NowW'($urandom_range(0, w / 2));
    else if (r < 45) return NowW'(w);
    else if (r < 70) return NowW'(w + 1 + $urandom_range(0, 3));
    else if (r < 80) return '0;
    else if (r < 92) return NowW'(w + $urandom_range(0, 3 * w + 10));
    else return $urandom();
  endfunction

  // release query, mostly aimed at the button of the gesture
  function automatic logic [QueryW-1:0] pick_query(input logic [QueryW-1:0] aim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return aim;
    else if (r < 80) return '0;
    else if (r < 95) return QueryW'($urandom_range(0, Buttons));
    else return QueryW'($urandom_range(Buttons + 1, 7));
  endfunction

  // press, hold and release of one chord, with some bounce
  task automatic press_gesture();
    logic [PressedW-1:0] chord;
    logic [QueryW-1:0]   aim;
    int unsigned         r;
    int unsigned         n;
    r = $urandom_range(0, 9);
    if (r < 4) chord = PressedW'(1) << $urandom_range(0, PressedW - 1);
    else if (r < 6) chord = 4'b0011;
    else if (r < 8) chord = 4'b0110;
    else chord = PressedW'($urandom_range(1, 15));
    aim = '0;
    for (int i = PressedW - 1; i >= 0; i--) begin
      if (chord[i]) aim = QueryW'(i + 1);
    end
    send_sample(chord, cur_now + pick_step(), $urandom_range(0, 9) == 0, pick_query(aim));
    // hold, classification falls somewhere in here
    n = $urandom_range(1, 4);
    repeat (n) begin
      send_sample(($urandom_range(0, 4) == 0) ? PressedW'($urandom()) : chord,
                  cur_now + pick_step(), $urandom_range(0, 4) == 0, pick_query(aim));
    end
    // release
    n = $urandom_range(1, 4);
    repeat (n) begin
      send_sample(($urandom_range(0, 9) == 0) ? PressedW'($urandom()) : '0,
                  cur_now + pick_step(), $urandom_range(0, 9) == 0, pick_query(aim));
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [SettleW-1:0] settings [NumSettings];
    int unsigned        target;
    rst_ni                  = 1'b0;
    sample_ch.valid         = 1'b0;
    sample_ch.pressed       = '0;
    sample_ch.now_ms        = '0;
    sample_ch.force_wait    = 1'b0;
    sample_ch.release_query = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.settle_ms        = '0;
    window                  = SettleMsReset;
    cur_now                 = '0;
    samples_sent            = 0;
    burst_mode              = 1'b0;
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'd50, SettleW'($urandom()), 16'd7, 16'd1000,
                 SettleW'($urandom_range(2, 30))};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part on the reset window of 50 ms
    send_sample(4'b0001, 32'd100, 1'b0, 3'd0);       // press from idle starts the window
    send_sample(4'b0001, 32'd150, 1'b0, 3'd0);       // exactly the window, not yet passed
    send_sample(4'b0001, 32'd151, 1'b0, 3'd1);       // single 1, query while still held
    send_sample(4'b0000, 32'd160, 1'b0, 3'd1);       // released button 1
    send_sample(4'b0000, 32'd202, 1'b0, 3'd0);       // back to idle
    send_sample(4'b0011, 32'd210, 1'b0, 3'd0);
    send_sample(4'b0011, 32'd261, 1'b0, 3'd0);       // bank down
    send_sample(4'b0000, 32'd400, 1'b0, 3'd0);
    send_sample(4'b0110, 32'd410, 1'b0, 3'd0);
    send_sample(4'b0110, 32'd500, 1'b0, 3'd0);       // bank up
    send_sample(4'b0000, 32'd600, 1'b0, 3'd0);
    send_sample(4'b0110, 32'd610, 1'b0, 3'd0);
    send_sample(4'b0110, 32'd700, 1'b1, 3'd0);       // force wait drops the chord
    send_sample(4'b0000, 32'd800, 1'b0, 3'd0);
    send_sample(4'b1111, 32'd810, 1'b0, 3'd0);
    send_sample(4'b1111, 32'd900, 1'b0, 3'd0);       // invalid combination
    send_sample(4'b1111, 32'd1000, 1'b1, 3'd0);      // force wait on invalid
    send_sample(4'b0000, 32'd1100, 1'b0, 3'd0);
    send_sample(4'b1000, 32'd1110, 1'b0, 3'd0);
    send_sample(4'b1000, 32'd1200, 1'b0, 3'd4);      // single 4, still held
    send_sample(4'b0000, 32'd1201, 1'b0, 3'd7);      // query above the button count
    send_sample(4'b0000, 32'd1300, 1'b1, 3'd4);      // release of 4, force has no effect
    send_sample(4'b0100, 32'hFFFF_FFF0, 1'b0, 3'd0); // window across the wrap
    send_sample(4'b0100, 32'h0000_0021, 1'b0, 3'd0);
    send_sample(4'b0100, 32'h0000_0023, 1'b1, 3'd3); // single still reported on force

    // random gestures and noise over several window settings
    for (int k = 0; k < NumSettings; k++) begin
      write_settle(settings[k]);
      target = samples_sent + SamplesPerWindow;
      while (samples_sent < target) begin
        burst_mode = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 99) < 80) begin
          press_gesture();
        end else begin
          send_sample(PressedW'($urandom()), cur_now + pick_step(), 1'($urandom()),
                      QueryW'($urandom()));
        end
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    // wait out the remaining results
    burst_mode = 1'b0;
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d samples and %0d checked results (%0d press or chord events)",
             samples_sent, checked, events);
    $display("over the reset window and %0d written settle windows, including 0 and 65535",
             NumSettings);
    if (fail_count == 0) begin
      $display("button_chord_detector_test: PASS");
    end else begin
      $display("button_chord_detector_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_if.sv
hw/rtl/bcd_fsm.sv
hw/rtl/button_chord_detector.sv
bench/button_chord_detector_checker.sv
bench/button_chord_detector_test.sv
